// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, screen geometry and a helper function for the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int SHIFT_CELLS = CELLS - COLUMNS;
  localparam int ADDR_W      = $clog2(CELLS);

  localparam int MODE_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int PVAL_W  = 7;
  localparam int IDX_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int POS_W   = 11;
  localparam int COLOR_W = 8;

  localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BKSP  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROW   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h0B;
  localparam logic [CELL_W-1:0]  RESET_BLANK  = {COLOR_RESET, SPACE_CODE};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic              join_line;
    logic [PVAL_W-1:0] position_value;
    logic [IDX_W-1:0]  cell_index;
    logic [CELL_W-1:0] cell_value;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] read_data;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

// ----- src/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor registers and the sequencer that drives the screen memory.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcw_pkg::item_t                item,
  input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
  input  logic                          out_free,
  output logic                          res_valid,
  output tcw_pkg::res_t                 res,
  output tcw_pkg::mem_wr_t              mem_wr,
  output logic                          rd_en,
  output logic [tcw_pkg::ADDR_W-1:0]    rd_addr,
  input  logic [tcw_pkg::CELL_W-1:0]    rd_data
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_BLANK  = 7'b0010000,
    S_JOIN   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] SHIFT_END = tcw_pkg::ADDR_W'(tcw_pkg::SHIFT_CELLS);

  state_t                         state_r, state_nxt;
  logic [tcw_pkg::ADDR_W-1:0]     cnt_r, cnt_nxt;
  logic [tcw_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [tcw_pkg::CELL_W-1:0]     rd_r, rd_nxt;
  logic [tcw_pkg::ADDR_W-1:0]     jbase_r, jbase_nxt;
  logic [tcw_pkg::COL_W-1:0]      scan_r, scan_nxt;
  logic [tcw_pkg::COL_W-1:0]      pend_col_r, pend_col_nxt;
  logic                           pend_v_r, pend_v_nxt;

  logic [tcw_pkg::CELL_W-1:0]     blank;
  logic                           idx_ok;
  logic                           accept;

  assign blank    = {text_color, tcw_pkg::SPACE_CODE};
  assign idx_ok   = {2'b00, item.cell_index} < 13'(tcw_pkg::CELLS);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    rd_nxt       = rd_r;
    jbase_nxt    = jbase_r;
    scan_nxt     = scan_r;
    pend_col_nxt = pend_col_r;
    pend_v_nxt   = pend_v_r;
    mem_wr       = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    res_valid    = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = cnt_r;
        mem_wr.data = tcw_pkg::RESET_BLANK;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          rd_nxt    = '0;
          state_nxt = S_DONE;
          case (item.mode)
            tcw_pkg::MODE_PUT: begin
              if (item.char_code != tcw_pkg::NEWLINE_CODE) begin
                mem_wr.we   = 1'b1;
                mem_wr.addr = tcw_pkg::cell_addr(row_r, col_r);
                mem_wr.data = {text_color, item.char_code};
              end
              if (item.char_code == tcw_pkg::NEWLINE_CODE || col_r == LAST_COL) begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  cnt_nxt   = '0;
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            tcw_pkg::MODE_BKSP: begin
              if (col_r != '0) begin
                col_nxt     = col_r - 1'b1;
                mem_wr.we   = 1'b1;
                mem_wr.addr = tcw_pkg::cell_addr(row_r, col_r - 1'b1);
                mem_wr.data = blank;
              end else if (item.join_line && row_r != '0) begin
                row_nxt    = row_r - 1'b1;
                jbase_nxt  = tcw_pkg::cell_addr(row_r - 1'b1, '0);
                scan_nxt   = LAST_COL;
                pend_v_nxt = 1'b0;
                state_nxt  = S_JOIN;
              end
            end
            tcw_pkg::MODE_ROW: begin
              if ({1'b0, item.position_value} >= 8'(tcw_pkg::ROWS)) begin
                row_nxt = LAST_ROW;
              end else begin
                row_nxt = tcw_pkg::ROW_W'(item.position_value);
              end
            end
            tcw_pkg::MODE_COL: begin
              if ({1'b0, item.position_value} >= 8'(tcw_pkg::COLUMNS)) begin
                col_nxt = LAST_COL;
              end else begin
                col_nxt = tcw_pkg::COL_W'(item.position_value);
              end
            end
            tcw_pkg::MODE_WRITE: begin
              mem_wr.we   = idx_ok;
              mem_wr.addr = tcw_pkg::ADDR_W'(item.cell_index);
              mem_wr.data = item.cell_value;
            end
            tcw_pkg::MODE_READ: begin
              if (idx_ok) begin
                rd_en     = 1'b1;
                rd_addr   = tcw_pkg::ADDR_W'(item.cell_index);
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        rd_nxt    = rd_data;
        state_nxt = S_DONE;
      end

      // Copy each cell one row up: read ahead one row, write the registered read
      // data to the address just behind the counter.
      S_SCROLL: begin
        rd_en       = (cnt_r != SHIFT_END);
        rd_addr     = cnt_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        mem_wr.we   = (cnt_r != '0);
        mem_wr.addr = cnt_r - 1'b1;
        mem_wr.data = rd_data;
        if (cnt_r == SHIFT_END) begin
          state_nxt = S_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_BLANK: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = cnt_r;
        mem_wr.data = blank;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // Scan the row right to left; stop at the first cell that is not blank, or at column 0.
      S_JOIN: begin
        rd_en        = !(pend_v_r && pend_col_r == '0);
        rd_addr      = jbase_r + tcw_pkg::ADDR_W'(scan_r);
        pend_v_nxt   = 1'b1;
        pend_col_nxt = scan_r;
        scan_nxt     = scan_r - 1'b1;
        if (pend_v_r) begin
          if (rd_data != blank) begin
            col_nxt   = (pend_col_r == LAST_COL) ? LAST_COL : pend_col_r + 1'b1;
            state_nxt = S_DONE;
          end else if (pend_col_r == '0) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cnt_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r       <= rd_nxt;
    jbase_r    <= jbase_nxt;
    scan_r     <= scan_nxt;
    pend_col_r <= pend_col_nxt;
  end

  assign res.cursor_row      = row_r;
  assign res.cursor_column   = col_r;
  assign res.cursor_position = tcw_pkg::POS_W'(tcw_pkg::cell_addr(row_r, col_r));
  assign res.read_data       = rd_r;

endmodule

// ----- src/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen memory of 16-bit cells plus a cursor.
// ----------------------------------------------------------------------------
// Input stream carries one command per transfer (put char, backspace, set
// row, set column, write cell, read cell) selected by in_tuser. Every command
// returns one transfer on the output stream with the cursor after the command
// and, for a cell read, the cell content.
// The cfg channel writes the attribute byte used for written and blank cells;
// cfg_ready is always high.
// A backspace that joins the previous row scans that row from the right, one
// memory read a cycle. A row advance on the last row scrolls the screen
// through the single memory port pair: one cell copied per cycle, then the
// bottom row blanked.
// One command is in flight at a time; in_tready is high only while idle.
// After reset a clearing pass writes the blank cell 0x0B20 to all
// ROWS * COLUMNS cells; in_tready stays low until it ends.
// A stalled output holds its transfer; the next command may be accepted
// meanwhile and finishes once the output register frees up.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] char_code, [14:8] position_value, [25:15] cell_index,
  // [41:26] cell_value, [47:42] zero
  input  logic [47:0] in_tdata,
  // [2:0] mode, [3] join_line
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] cursor_row, [11:5] cursor_column, [22:12] cursor_position,
  // [38:23] read_data, [39] zero
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  tcw_pkg::item_t                item;
  tcw_pkg::res_t                 res;
  tcw_pkg::mem_wr_t              mem_wr;
  logic                          res_valid;
  logic                          out_free;
  logic                          rd_en;
  logic [tcw_pkg::ADDR_W-1:0]    rd_addr;
  logic [tcw_pkg::CELL_W-1:0]    rd_data;

  logic [tcw_pkg::COLOR_W-1:0]   text_color_r;
  logic                          out_valid_r;
  tcw_pkg::res_t                 out_res_r;

  assign item.mode           = in_tuser[2:0];
  assign item.join_line      = in_tuser[3];
  assign item.char_code      = in_tdata[7:0];
  assign item.position_value = in_tdata[14:8];
  assign item.cell_index     = in_tdata[25:15];
  assign item.cell_value     = in_tdata[41:26];

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::COLOR_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_color_r <= cfg_data;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .text_color(text_color_r),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_wr    (mem_wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (mem_wr.we),
    .waddr(mem_wr.addr),
    .wdata(mem_wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.read_data, out_res_r.cursor_position,
                       out_res_r.cursor_column, out_res_r.cursor_row};

endmodule

// ----- src/tcw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata
);

  logic [tcw_pkg::POS_W-1:0] exp_pos;

  assign exp_pos = tcw_pkg::POS_W'(tcw_pkg::cell_addr(out_tdata[4:0], out_tdata[11:5]));

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transfer changed");

  // One command in flight: no accept right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in flight");

  // Cursor stays on screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] < 5'(tcw_pkg::ROWS))
                && ({1'b0, out_tdata[11:5]} < 8'(tcw_pkg::COLUMNS)))
    else $error("cursor outside the screen");

  // Linear cursor address agrees with row and column.
  a_cursor_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:12] == exp_pos)
    else $error("cursor position does not match row and column");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console writer.
// ----------------------------------------------------------------------------
// A shadow screen, cursor and attribute byte track every accepted command.
// Each command queues the cursor report it should produce, and each output
// transfer is checked field by field against the oldest queued report. A
// short directed sequence covers the corner cases, then random traffic runs
// under several attribute settings. Both sides idle at random, and the
// output side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT       = 8000000;
  localparam int LONG_STALL_AT     = 300;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int PHASE_ITEMS       = 210;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  text_console_writer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the block
  logic [CELL_W-1:0]  screen_model [CELLS];
  logic [COLOR_W-1:0] text_attr = COLOR_RESET;
  int cur_row = 0;
  int cur_col = 0;

  item_t pending_commands [$];
  res_t  cursor_reports [$];

  int n_pushed = 0;
  int n_issued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_results_seen = 0;
  int n_color_writes = 0;
  int n_errors = 0;
  int n_scrolls = 0;
  int n_joins = 0;
  int n_mode [8];
  int cycles = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int last_write_idx = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit long_stall_done = 1'b0;

  function automatic void advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < SHIFT_CELLS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = SHIFT_CELLS; i < CELLS; i++) screen_model[i] = {text_attr, SPACE_CODE};
      cur_row = ROWS - 1;
      n_scrolls++;
    end
  endfunction

  function automatic res_t apply_command(item_t c);
    res_t              r;
    logic [CELL_W-1:0] rd;
    logic [CELL_W-1:0] blank;
    bit                found;
    rd = '0;
    blank = {text_attr, SPACE_CODE};
    n_mode[c.mode]++;
    case (c.mode)
      MODE_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          advance_row();
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {text_attr, c.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) advance_row();
        end
      end
      MODE_BKSP: begin
        if (cur_col > 0) begin
          cur_col--;
          screen_model[cur_row * COLUMNS + cur_col] = blank;
        end else if (c.join_line && cur_row > 0) begin
          // land one past the rightmost non-blank cell of the row above, capped at the last column
          cur_row--;
          n_joins++;
          found = 1'b0;
          for (int x = COLUMNS; x > 0 && !found; x--) begin
            if (screen_model[cur_row * COLUMNS + x - 1] != blank) begin
              cur_col = (x >= COLUMNS) ? COLUMNS - 1 : x;
              found = 1'b1;
            end
          end
        end
      end
      MODE_ROW: cur_row = (c.position_value >= ROWS) ? ROWS - 1 : int'(c.position_value);
      MODE_COL: cur_col = (c.position_value >= COLUMNS) ? COLUMNS - 1 : int'(c.position_value);
      MODE_WRITE: if (c.cell_index < CELLS) screen_model[c.cell_index] = c.cell_value;
      MODE_READ: if (c.cell_index < CELLS) rd = screen_model[c.cell_index];
      default: ;
    endcase
    r.cursor_row      = ROW_W'(cur_row);
    r.cursor_column   = COL_W'(cur_col);
    r.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    r.read_data       = rd;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // transfers on all three channels, shadow update, report checking
  always @(posedge clk) begin
    item_t c;
    res_t  want;
    res_t  got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        text_attr = cfg_data;
        n_color_writes++;
      end
      if (in_tvalid && in_tready) begin
        c.char_code      = in_tdata[7:0];
        c.position_value = in_tdata[14:8];
        c.cell_index     = in_tdata[25:15];
        c.cell_value     = in_tdata[41:26];
        c.mode           = in_tuser[2:0];
        c.join_line      = in_tuser[3];
        cursor_reports.push_back(apply_command(c));
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        got.cursor_row      = out_tdata[4:0];
        got.cursor_column   = out_tdata[11:5];
        got.cursor_position = out_tdata[22:12];
        got.read_data       = out_tdata[38:23];
        if (cursor_reports.size() == 0) begin
          $error("output transfer with no command outstanding: %h", out_tdata);
          n_errors++;
        end else begin
          want = cursor_reports.pop_front();
          check_field("cursor_row", want.cursor_row, got.cursor_row);
          check_field("cursor_column", want.cursor_column, got.cursor_column);
          check_field("cursor_position", want.cursor_position, got.cursor_position);
          check_field("read_data", want.read_data, got.read_data);
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    logic  offer;
    item_t c;
    if (rst_n) begin
      offer = in_tvalid && (n_accepted != n_issued);
      if (!offer) begin
        if (in_tvalid) begin
          if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 10);
        end
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_commands.size() > 0) begin
          c = pending_commands.pop_front();
          in_tdata <= {6'b0, c.cell_value, c.cell_index, c.position_value, c.char_code};
          in_tuser <= {c.join_line, c.mode};
          n_issued++;
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // report receiver: random stalls, one long hold-off
  always @(negedge clk) begin
    logic take_ready;
    if (rst_n) begin
      take_ready = out_tready;
      if (out_tready && n_results != n_results_seen) begin
        n_results_seen = n_results;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        recv_hold = recv_burst ? 0 : $urandom_range(0, 10);
        if (!long_stall_done && n_results >= LONG_STALL_AT) begin
          recv_hold = LONG_STALL_CYCLES;
          long_stall_done = 1'b1;
        end
        take_ready = 1'b0;
      end
      if (!take_ready) begin
        if (recv_hold > 0) recv_hold--;
        else take_ready = 1'b1;
      end
      out_tready <= take_ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void queue_command(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] code,
                                        logic join_row, logic [PVAL_W-1:0] pos,
                                        logic [IDX_W-1:0] idx, logic [CELL_W-1:0] val);
    item_t c;
    c.mode           = mode;
    c.char_code      = code;
    c.join_line      = join_row;
    c.position_value = pos;
    c.cell_index     = idx;
    c.cell_value     = val;
    pending_commands.push_back(c);
    n_pushed++;
  endfunction

  // text most often, with some newlines and backspaces, cursor moves, cell access and spare modes
  function automatic void queue_random_command();
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] code;
    logic              join_row;
    logic [PVAL_W-1:0] pos;
    logic [IDX_W-1:0]  idx;
    int                pick;
    code     = CHAR_W'($urandom);
    join_row = 1'($urandom);
    pos      = PVAL_W'($urandom);
    idx      = IDX_W'($urandom);
    pick     = $urandom_range(0, 99);
    if (pick < 40) begin
      mode = MODE_PUT;
      if ($urandom_range(0, 11) == 0) code = NEWLINE_CODE;
    end else if (pick < 55) begin
      mode = MODE_BKSP;
      join_row = ($urandom_range(0, 2) != 0);
    end else if (pick < 62) begin
      mode = MODE_ROW;
      if ($urandom_range(0, 4) != 0) pos = PVAL_W'($urandom_range(0, ROWS - 1));
    end else if (pick < 69) begin
      mode = MODE_COL;
      if ($urandom_range(0, 4) != 0) pos = PVAL_W'($urandom_range(0, COLUMNS - 1));
    end else if (pick < 81) begin
      mode = MODE_WRITE;
      if ($urandom_range(0, 9) != 0) idx = IDX_W'($urandom_range(0, CELLS - 1));
      last_write_idx = int'(idx);
    end else if (pick < 97) begin
      mode = MODE_READ;
      pick = $urandom_range(0, 9);
      if (pick < 3) idx = IDX_W'(last_write_idx);
      else if (pick < 9) idx = IDX_W'($urandom_range(0, CELLS - 1));
    end else begin
      mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    end
    queue_command(mode, code, join_row, pos, idx, CELL_W'($urandom));
  endfunction

  // settle, change the attribute byte, then run a batch of random commands
  task automatic run_phase(input logic [COLOR_W-1:0] color, input int count);
    int target;
    while (n_accepted != n_pushed || cursor_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    target = n_color_writes + 1;
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    @(negedge clk);
    while (n_color_writes < target) @(negedge clk);
    cfg_valid <= 1'b0;
    repeat (count) queue_random_command();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_BLANK;
    for (int i = 0; i < 8; i++) n_mode[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corner cases, reset attribute byte
    queue_command(MODE_READ, 8'h00, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_READ, 8'h00, 1'b0, 7'd0, 11'd2000, 16'h0000);
    queue_command(MODE_READ, 8'hFF, 1'b1, 7'h7F, 11'h7FF, 16'hFFFF);
    queue_command(MODE_WRITE, 8'h00, 1'b0, 7'd0, 11'd1999, 16'hFFFF);
    queue_command(MODE_WRITE, 8'h00, 1'b0, 7'd0, 11'h7FF, 16'h1234);
    queue_command(MODE_READ, 8'h00, 1'b0, 7'd0, 11'd1999, 16'h0000);
    queue_command(MODE_WRITE, 8'h00, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_PUT, 8'h41, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_PUT, 8'hFF, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_PUT, 8'h00, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_BKSP, 8'h00, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_PUT, NEWLINE_CODE, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_BKSP, 8'h00, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_BKSP, 8'h00, 1'b1, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_ROW, 8'h00, 1'b0, 7'h7F, 11'd0, 16'h0000);
    queue_command(MODE_COL, 8'h00, 1'b0, 7'h7F, 11'd0, 16'h0000);
    queue_command(MODE_PUT, 8'h5A, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_READ, 8'h00, 1'b0, 7'd0, 11'd1919, 16'h0000);
    queue_command(MODE_ROW, 8'h00, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_BKSP, 8'h00, 1'b1, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_WRITE, 8'h00, 1'b0, 7'd0, 11'd79, 16'h4142);
    queue_command(MODE_ROW, 8'h00, 1'b0, 7'd1, 11'd0, 16'h0000);
    queue_command(MODE_BKSP, 8'h00, 1'b1, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_ROW, 8'h00, 1'b0, 7'd24, 11'd0, 16'h0000);
    queue_command(MODE_PUT, NEWLINE_CODE, 1'b0, 7'd0, 11'd0, 16'h0000);
    queue_command(MODE_SPARE_LO, 8'h41, 1'b1, 7'd5, 11'd5, 16'h5555);
    queue_command(MODE_SPARE_HI, 8'h42, 1'b0, 7'd6, 11'd6, 16'hAAAA);

    run_phase(8'h00, PHASE_ITEMS);
    run_phase(8'hFF, PHASE_ITEMS);
    run_phase(COLOR_W'($urandom), PHASE_ITEMS);
    run_phase(COLOR_W'($urandom), PHASE_ITEMS);

    // drain
    while (n_accepted != n_pushed || cursor_reports.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (cursor_reports.size() != 0) begin
      $error("%0d cursor reports never arrived", cursor_reports.size());
    end

    $display("summary: %0d cmds: %0d put %0d bksp %0d row %0d col %0d wr %0d rd %0d spare",
             n_accepted, n_mode[MODE_PUT], n_mode[MODE_BKSP], n_mode[MODE_ROW],
             n_mode[MODE_COL], n_mode[MODE_WRITE], n_mode[MODE_READ],
             n_mode[MODE_SPARE_LO] + n_mode[MODE_SPARE_HI]);
    $display("summary: %0d scrolls, %0d row joins, %0d attribute writes, long stall %0s",
             n_scrolls, n_joins, n_color_writes, long_stall_done ? "seen" : "missed");
    if (n_errors == 0 && cursor_reports.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
